### src/u8u16_pkg.sv
`timescale 1ns / 1ps

package u8u16_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [20:0] SUPP_BASE = 21'h10000;
  localparam logic [15:0] HI_SURR   = 16'hD800;
  localparam logic [15:0] LO_SURR   = 16'hDC00;

  // one decoded code point or error, queued for the back end
  typedef struct packed {
    logic        err;
    logic        eos;
    logic [20:0] cp;
  } job_t;

  typedef enum logic {
    PH_FIRST,
    PH_SECOND
  } phase_t;

endpackage

### src/u8u16_front.sv
`timescale 1ns / 1ps

module u8u16_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         in_byte,
  input  logic               in_eos,
  output logic               push,
  output u8u16_pkg::job_t    push_job
);

  logic [20:0] pcp, pcp_next;
  logic [1:0]  rem, rem_next;
  logic        disc, disc_next;
  logic [20:0] shifted;
  logic [1:0]  rem_dec;

  assign shifted = {pcp[14:0], in_byte[5:0]};
  assign rem_dec = rem - 2'd1;

  always_comb begin
    pcp_next      = pcp;
    rem_next      = rem;
    disc_next     = disc;
    push          = 1'b0;
    push_job.err  = 1'b0;
    push_job.eos  = in_eos;
    push_job.cp   = 21'd0;
    if (accept) begin
      if (disc) begin
        if (in_eos) begin
          disc_next = 1'b0;
        end
      end else if (rem != 2'd0) begin
        pcp_next = shifted;
        rem_next = rem_dec;
        if (rem_dec == 2'd0) begin
          push        = 1'b1;
          push_job.cp = shifted;
          pcp_next    = 21'd0;
        end else if (in_eos) begin
          push         = 1'b1;
          push_job.err = 1'b1;
          pcp_next     = 21'd0;
          rem_next     = 2'd0;
        end
      end else begin
        priority if (!in_byte[7]) begin
          push        = 1'b1;
          push_job.cp = {13'd0, in_byte};
        end else if (in_byte[7:5] == 3'b110 || in_byte[7:4] == 4'b1110
                     || in_byte[7:3] == 5'b11110) begin
          if (in_eos) begin
            push         = 1'b1;
            push_job.err = 1'b1;
          end else if (in_byte[7:5] == 3'b110) begin
            pcp_next = {16'd0, in_byte[4:0]};
            rem_next = 2'd1;
          end else if (in_byte[7:4] == 4'b1110) begin
            pcp_next = {17'd0, in_byte[3:0]};
            rem_next = 2'd2;
          end else begin
            pcp_next = {18'd0, in_byte[2:0]};
            rem_next = 2'd3;
          end
        end else begin
          push         = 1'b1;
          push_job.err = 1'b1;
          disc_next    = !in_eos;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pcp  <= 21'd0;
      rem  <= 2'd0;
      disc <= 1'b0;
    end else begin
      pcp  <= pcp_next;
      rem  <= rem_next;
      disc <= disc_next;
    end
  end

endmodule

### src/u8u16_queue.sv
`timescale 1ns / 1ps

module u8u16_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  u8u16_pkg::job_t push_job,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output u8u16_pkg::job_t head_job
);

  u8u16_pkg::job_t mem [u8u16_pkg::QDEPTH];
  logic [u8u16_pkg::QAW-1:0] wr_ptr, rd_ptr;
  logic [u8u16_pkg::QAW:0]   count;
  logic                      do_push, do_pop;

  assign full       = (count == (u8u16_pkg::QAW+1)'(u8u16_pkg::QDEPTH));
  assign head_valid = (count != '0);
  assign head_job   = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### src/u8u16_back.sv
`timescale 1ns / 1ps

module u8u16_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  u8u16_pkg::job_t head_job,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [15:0]     out_unit,
  output logic            out_err,
  output logic            out_last,
  output logic            out_done
);

  u8u16_pkg::phase_t phase, phase_next;
  logic        load;
  logic        is_pair;
  logic [20:0] sub;
  logic [15:0] unit_d;
  logic        last_d, done_d;

  assign load    = head_valid && (!out_valid || out_ready);
  assign is_pair = !head_job.err && (head_job.cp[20:16] != 5'd0);
  assign sub     = head_job.cp - u8u16_pkg::SUPP_BASE;

  always_comb begin
    phase_next = phase;
    if (load && is_pair) begin
      unique case (phase)
        u8u16_pkg::PH_FIRST:  phase_next = u8u16_pkg::PH_SECOND;
        u8u16_pkg::PH_SECOND: phase_next = u8u16_pkg::PH_FIRST;
        default:              phase_next = u8u16_pkg::PH_FIRST;
      endcase
    end
  end

  always_comb begin
    unit_d = head_job.cp[15:0];
    last_d = 1'b1;
    done_d = head_job.eos;
    pop    = load;
    if (head_job.err) begin
      unit_d = 16'd0;
    end else if (is_pair) begin
      unique case (phase)
        u8u16_pkg::PH_FIRST: begin
          unit_d = u8u16_pkg::HI_SURR + {5'd0, sub[20:10]};
          last_d = 1'b0;
          done_d = 1'b0;
          pop    = 1'b0;
        end
        default: begin
          unit_d = u8u16_pkg::LO_SURR | {6'd0, sub[9:0]};
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= u8u16_pkg::PH_FIRST;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_unit <= unit_d;
      out_err  <= head_job.err;
      out_last <= last_d;
      out_done <= done_d;
    end
  end

endmodule

### src/utf8_to_utf16_converter.sv
`timescale 1ns / 1ps

// channel  dir  tdata              tuser                    tlast
// s_axis   in   [7:0] input_byte   -                        end_of_string
// m_axis   out  [15:0] code_unit   [0] error [1] string_done last_of_run
//
// One byte per cycle in while the job queue has room; one result per cycle out while
// jobs are queued and m_tready is high, so a code point that makes a surrogate pair
// gives two results in the back end. Decode is combinational and the job is written
// into the queue at the accepting edge; the back end then registers the result from
// the queue head, and a pair's low unit follows its high unit. Reset clears the decode
// state, the four-entry job queue and the output valid flag. The input stalls only when
// the job queue is full; the output register holds a waiting result and is refilled only as it is taken.

module utf8_to_utf16_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] input_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] code_unit
  output logic [1:0]  m_tuser,   // [0] error, [1] string_done
  output logic        m_tlast
);

  logic            full, push, pop, head_valid, accept;
  u8u16_pkg::job_t push_job, head_job;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  u8u16_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_byte  (s_tdata),
    .in_eos   (s_tlast),
    .push     (push),
    .push_job (push_job)
  );

  u8u16_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  u8u16_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_unit   (m_tdata),
    .out_err    (m_tuser[0]),
    .out_last   (m_tlast),
    .out_done   (m_tuser[1])
  );

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == 16'd0)
    else $error("error result with nonzero code unit");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tlast)
    else $error("error result not last of run");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast)
    else $error("string_done without last_of_run");

  a_high_surr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[15:11] == 5'b11011)
    else $error("first unit of a pair is not a high surrogate");

endmodule
